### hw/rtl/ksr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key escape sequence recognizer package
// Shared widths, register map constants and controller/datapath interfaces.
// ----------------------------------------------------------------------------
package ksr_pkg;

    localparam int DATA_W            = 8;
    localparam int QUEUE_DEPTH       = 4;
    localparam int QIDX_W            = 2;
    localparam int COUNT_W           = 3;
    localparam int KEY_W             = 4;
    localparam int MAX_KEYS          = 15;
    localparam int MAX_PATTERN_BYTES = 4;
    localparam int PATTERN_W         = 32;
    localparam int REG_COUNT         = 8;
    localparam int REG_IDX_W         = 3;
    localparam int CFG_W             = 64;
    localparam int ADDR_W            = 6;

    localparam int PATTERN_BYTES_DEF = 4;
    localparam int KEY_COUNT_DEF     = 15;

    // Register index of the last, 32-bit wide pattern register (function key 9).
    localparam logic [REG_IDX_W-1:0] REG_FN9 = 3'd7;

    typedef logic [REG_COUNT-1:0][CFG_W-1:0] pattern_bank_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic push;       // load the accepted byte into the pending queue
        logic advance;    // consume the decided bytes and capture their result
        logic send;       // move the captured result into the output register
        logic send_last;  // the sent result closes the run of this byte
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic has_result; // the queue is non-empty and not held by a lead-in
        logic out_free;   // the output register can take a result this cycle
    } dp_status_t;

endpackage

### hw/rtl/ksr_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pattern register bank
// APB-style register file holding the key patterns, two per 64-bit register.
// ----------------------------------------------------------------------------
module ksr_regs
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ksr_pkg::ADDR_W-1:0]     paddr,
    input  logic [ksr_pkg::CFG_W-1:0]      pwdata,
    output logic [ksr_pkg::CFG_W-1:0]      prdata,
    output logic                           pready,
    output ksr_pkg::pattern_bank_t         patterns
);

    ksr_pkg::pattern_bank_t               patterns_reg;
    logic [ksr_pkg::REG_IDX_W-1:0]        reg_idx;
    logic                                 wr_en;

    assign reg_idx = paddr[ksr_pkg::ADDR_W-1:ksr_pkg::ADDR_W-ksr_pkg::REG_IDX_W];
    assign wr_en   = psel && penable && pwrite && pready;
    assign pready  = 1'b1;
    assign prdata  = patterns_reg[reg_idx];
    assign patterns = patterns_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            patterns_reg <= '0;
        end
        else if (wr_en)
        begin
            // The function key 9 register is only 32 bits wide.
            if (reg_idx == ksr_pkg::REG_FN9)
            begin
                patterns_reg[reg_idx] <= {{(ksr_pkg::CFG_W-ksr_pkg::PATTERN_W){1'b0}},
                                          pwdata[ksr_pkg::PATTERN_W-1:0]};
            end
            else
            begin
                patterns_reg[reg_idx] <= pwdata;
            end
        end
    end

endmodule

### hw/rtl/ksr_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Recognizer datapath
// Pending byte queue, parallel pattern compare, result capture and output stage.
// ----------------------------------------------------------------------------
module ksr_datapath #(
    parameter int PATTERN_BYTES = ksr_pkg::PATTERN_BYTES_DEF,
    parameter int KEY_COUNT     = ksr_pkg::KEY_COUNT_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  ksr_pkg::pattern_bank_t        patterns,
    input  logic [ksr_pkg::DATA_W-1:0]    rx_char,
    input  ksr_pkg::ctrl_cmd_t            cmd,
    output ksr_pkg::dp_status_t           status,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [ksr_pkg::DATA_W-1:0]    m_tdata,
    output logic                          m_tuser,
    output logic                          m_tlast
);

    logic [ksr_pkg::DATA_W-1:0]  q_reg [ksr_pkg::QUEUE_DEPTH];
    logic [ksr_pkg::COUNT_W-1:0] count_reg;
    logic                        held_is_key_reg;
    logic [ksr_pkg::DATA_W-1:0]  held_value_reg;
    logic                        out_valid_reg;
    logic [ksr_pkg::DATA_W-1:0]  out_value_reg;
    logic                        out_is_key_reg;
    logic                        out_last_reg;

    logic                        hit_found;
    logic                        hit_lead;
    logic [ksr_pkg::KEY_W-1:0]   hit_key;
    logic [ksr_pkg::COUNT_W-1:0] hit_len;
    logic [ksr_pkg::COUNT_W-1:0] drop_n;
    logic [ksr_pkg::DATA_W-1:0]  q_adv [ksr_pkg::QUEUE_DEPTH];

    // Check every enabled key against the queue; the lowest key with an exact
    // match or a lead-in wins.
    always_comb
    begin
        logic [ksr_pkg::PATTERN_W-1:0] pat;
        logic [ksr_pkg::COUNT_W-1:0]   len;
        logic                          ok;
        hit_found = 1'b0;
        hit_lead  = 1'b0;
        hit_key   = '0;
        hit_len   = '0;
        for (int k = 0; k < KEY_COUNT; k++)
        begin
            pat = patterns[ksr_pkg::REG_IDX_W'(k >> 1)][(k % 2) * ksr_pkg::PATTERN_W +:
                                                        ksr_pkg::PATTERN_W];
            // Pattern length: position of the first zero byte.
            len = ksr_pkg::COUNT_W'(PATTERN_BYTES);
            for (int j = PATTERN_BYTES - 1; j >= 1; j--)
            begin
                if (pat[j * ksr_pkg::DATA_W +: ksr_pkg::DATA_W] == '0)
                begin
                    len = ksr_pkg::COUNT_W'(j);
                end
            end
            ok = 1'b1;
            for (int j = 0; j < PATTERN_BYTES; j++)
            begin
                if ((ksr_pkg::COUNT_W'(j) < len) && (ksr_pkg::COUNT_W'(j) < count_reg) &&
                    (pat[j * ksr_pkg::DATA_W +: ksr_pkg::DATA_W] != q_reg[j]))
                begin
                    ok = 1'b0;
                end
            end
            if (!hit_found && (count_reg != '0) &&
                (pat[ksr_pkg::DATA_W-1:0] != '0) && ok)
            begin
                hit_found = 1'b1;
                hit_lead  = (len > count_reg);
                hit_key   = ksr_pkg::KEY_W'(k);
                hit_len   = len;
            end
        end
    end

    assign drop_n = hit_found ? hit_len : ksr_pkg::COUNT_W'(1);

    // Queue contents after consuming the decided bytes.
    always_comb
    begin
        logic [ksr_pkg::COUNT_W-1:0] src;
        for (int i = 0; i < ksr_pkg::QUEUE_DEPTH; i++)
        begin
            src = ksr_pkg::COUNT_W'(i) + drop_n;
            if (src < ksr_pkg::COUNT_W'(ksr_pkg::QUEUE_DEPTH))
            begin
                q_adv[i] = q_reg[src[ksr_pkg::QIDX_W-1:0]];
            end
            else
            begin
                q_adv[i] = q_reg[i];
            end
        end
    end

    assign status.has_result = (count_reg != '0) && !(hit_found && hit_lead);
    assign status.out_free   = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.push)
        begin
            if (count_reg == ksr_pkg::COUNT_W'(ksr_pkg::QUEUE_DEPTH))
            begin
                count_reg <= count_reg;
            end
            else
            begin
                count_reg <= count_reg + ksr_pkg::COUNT_W'(1);
            end
        end
        else if (cmd.advance)
        begin
            count_reg <= count_reg - drop_n;
        end
    end

    // Queue entries and the captured result are payload and need no reset.
    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            if (count_reg == ksr_pkg::COUNT_W'(ksr_pkg::QUEUE_DEPTH))
            begin
                // A full queue drops its oldest byte without a result.
                for (int i = 0; i < ksr_pkg::QUEUE_DEPTH - 1; i++)
                begin
                    q_reg[i] <= q_reg[i + 1];
                end
                q_reg[ksr_pkg::QUEUE_DEPTH-1] <= rx_char;
            end
            else
            begin
                q_reg[count_reg[ksr_pkg::QIDX_W-1:0]] <= rx_char;
            end
        end
        else if (cmd.advance)
        begin
            q_reg           <= q_adv;
            held_is_key_reg <= hit_found;
            held_value_reg  <= hit_found ? ksr_pkg::DATA_W'(hit_key) : q_reg[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.send)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.send)
        begin
            out_value_reg  <= held_value_reg;
            out_is_key_reg <= held_is_key_reg;
            out_last_reg   <= cmd.send_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_value_reg;
    assign m_tuser  = out_is_key_reg;
    assign m_tlast  = out_last_reg;

endmodule

### hw/rtl/ksr_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Recognizer controller
// Sequences byte acceptance, one pattern decision per cycle while the output is free, and result output.
// ----------------------------------------------------------------------------
module ksr_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  ksr_pkg::dp_status_t  status,
    output ksr_pkg::ctrl_cmd_t   cmd
);

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_CHECK
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   held_valid_reg;
    logic   held_valid_next;

    assign s_tready = (state_reg == ST_IDLE);

    // One result is held back until the next decision shows whether it closes
    // the run of the current byte.
    always_comb
    begin
        state_next      = state_reg;
        held_valid_next = held_valid_reg;
        cmd             = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.push        = 1'b1;
                    held_valid_next = 1'b0;
                    state_next      = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (status.has_result)
                begin
                    if (!held_valid_reg)
                    begin
                        cmd.advance     = 1'b1;
                        held_valid_next = 1'b1;
                    end
                    else if (status.out_free)
                    begin
                        cmd.send    = 1'b1;
                        cmd.advance = 1'b1;
                    end
                end
                else if (held_valid_reg)
                begin
                    if (status.out_free)
                    begin
                        cmd.send        = 1'b1;
                        cmd.send_last   = 1'b1;
                        held_valid_next = 1'b0;
                        state_next      = ST_IDLE;
                    end
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            held_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            held_valid_reg <= held_valid_next;
        end
    end

endmodule

### hw/rtl/key_escape_sequence_recognizer.sv
`timescale 1ns / 1ps
// Flow: each byte yields 0 to 4 results, one pattern decision per cycle while the
// output register is free; a result goes through the held register into the output
// register, and the next byte is taken only once its last result has been sent.
// Reset: the pending queue is empty, all patterns read zero (every key undefined)
// and the output register holds no result.
// ----------------------------------------------------------------------------
// Key escape sequence recognizer
// Turns received terminal bytes into plain characters and configured key codes.
// ----------------------------------------------------------------------------
//
// Received bytes enter a four-entry pending queue. After each byte transfer the
// controller repeatedly asks the datapath for a decision on the queue: all
// enabled keys are compared in parallel against the queue and the lowest key
// that either matches exactly or is still a lead-in wins. A lead-in stops the
// run and the block waits for the next byte. An exact match consumes the
// pattern bytes and yields the key index; with no winner the oldest byte is
// yielded as a plain character. Each result is held back until the next
// decision so that the final result of the run can be marked with tlast.
//
// A result sits in an output register, so a result may wait for m_tready while
// the block already returns to idle and can take the next byte.
module key_escape_sequence_recognizer #(
    parameter int PATTERN_BYTES = ksr_pkg::PATTERN_BYTES_DEF,
    parameter int KEY_COUNT     = ksr_pkg::KEY_COUNT_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    // Received byte stream.
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [ksr_pkg::DATA_W-1:0]    s_tdata,   // [7:0] rx_char
    // Result stream.
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [ksr_pkg::DATA_W-1:0]    m_tdata,   // [7:0] value
    output logic                          m_tuser,   // [0] is_key
    output logic                          m_tlast,   // last_of_run
    // Configuration port.
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ksr_pkg::ADDR_W-1:0]    paddr,
    input  logic [ksr_pkg::CFG_W-1:0]     pwdata,
    output logic [ksr_pkg::CFG_W-1:0]     prdata,
    output logic                          pready
);

    ksr_pkg::pattern_bank_t patterns;
    ksr_pkg::ctrl_cmd_t     cmd;
    ksr_pkg::dp_status_t    status;

    // Pattern registers: register i at byte address 8*i.
    ksr_regs u_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .patterns (patterns)
    );

    // Sequencing of accept, decide and send.
    ksr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Queue, compare logic and output register.
    ksr_datapath #(
        .PATTERN_BYTES (PATTERN_BYTES),
        .KEY_COUNT     (KEY_COUNT)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .patterns (patterns),
        .rx_char  (s_tdata),
        .cmd      (cmd),
        .status   (status),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
